// ===== hw/rtl/cvs_pkg.sv =====
`timescale 1ns / 1ps

package cvs_pkg;

   localparam int COORD_IN_BITS = 16;
   localparam int COORD_BITS    = COORD_IN_BITS + 1;

   localparam int CHUNK_SIDE_LOG   = 4;
   localparam int CHUNK_TALL_LOG   = 5;
   localparam int WORLD_CHUNKS_LOG = 2;
   localparam int ID_BITS          = 8;

   localparam int ADDR_BITS   = 2 * WORLD_CHUNKS_LOG + 2 * CHUNK_SIDE_LOG + CHUNK_TALL_LOG;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;

   localparam logic [CHUNK_SIDE_LOG-1:0]   LOCAL_LAST  = '1;
   localparam logic [CHUNK_SIDE_LOG-1:0]   LOCAL_FIRST = '0;
   localparam logic [WORLD_CHUNKS_LOG-1:0] CHUNK_LAST  = '1;
   localparam logic [WORLD_CHUNKS_LOG-1:0] CHUNK_FIRST = '0;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [2:0] FACE_NONE  = 3'd0;
   localparam logic [2:0] FACE_XN    = 3'd1;
   localparam logic [2:0] FACE_XP    = 3'd2;
   localparam logic [2:0] FACE_YN    = 3'd3;
   localparam logic [2:0] FACE_YP    = 3'd4;
   localparam logic [2:0] FACE_ZN    = 3'd5;
   localparam logic [2:0] FACE_ZP    = 3'd6;
   localparam logic [2:0] FACE_SPARE = 3'd7;

   localparam int MASK_OWN   = 0;
   localparam int MASK_POS_X = 1;
   localparam int MASK_NEG_X = 2;
   localparam int MASK_POS_Z = 3;
   localparam int MASK_NEG_Z = 4;

   typedef struct packed {
      logic       in_world;
      logic       is_read;
      logic [4:0] mask;
   } stage_type;

endpackage

// ===== hw/rtl/chunked_voxel_store_core.sv =====
`timescale 1ns / 1ps
// channel | ports                                              | dir
// req     | req_valid/ready, type, world_x/y/z, new_block_id, place_face | in
// rsp     | rsp_valid/ready, in_world, read_value, remesh_mask             | out
//
// One beat per cycle while rsp is not stalled; a req beat passes the s1 stage
// and store RAM read register, then the rsp register that drives rsp_valid.
// After reset a clearing pass zeroes the store, one entry a cycle, over all
// 131072 entries, with req_ready low.
// A stalled rsp holds the stage behind it; req_ready drops when both are full.

module chunked_voxel_store_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [15:0] req_world_x,
   input  logic signed [15:0] req_world_y,
   input  logic signed [15:0] req_world_z,
   input  logic [7:0]         req_new_block_id,
   input  logic [2:0]         req_place_face,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_in_world,
   output logic [7:0]         rsp_read_value,
   output logic [4:0]         rsp_remesh_mask
);

   localparam int CB = cvs_pkg::COORD_BITS;
   localparam int SL = cvs_pkg::CHUNK_SIDE_LOG;
   localparam int TL = cvs_pkg::CHUNK_TALL_LOG;
   localparam int WL = cvs_pkg::WORLD_CHUNKS_LOG;
   localparam int AB = cvs_pkg::ADDR_BITS;
   localparam int IB = cvs_pkg::ID_BITS;

   logic signed [CB-1:0] wx, wy, wz;
   logic [WL-1:0]        cx, cz;
   logic [SL-1:0]        lx, lz;
   logic [TL-1:0]        ly;
   logic                 in_world;
   logic                 is_write;
   logic [4:0]           mask;
   logic [AB-1:0]        addr;
   logic                 req_fire;
   logic                 s1_move;

   logic                 clr_busy_ff, clr_busy_in;
   logic [AB-1:0]        clr_addr_ff, clr_addr_in;
   logic                 s1_valid_ff, s1_valid_in;
   cvs_pkg::stage_type   s1_ff, s1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_in_world_ff, rsp_in_world_in;
   logic [7:0]           rsp_read_value_ff, rsp_read_value_in;
   logic [4:0]           rsp_remesh_mask_ff, rsp_remesh_mask_in;

   logic                 ram_wr_en;
   logic [AB-1:0]        ram_wr_addr;
   logic [IB-1:0]        ram_wr_data;
   logic [IB-1:0]        ram_rd_data;

   always_comb begin
      is_write = (req_type == cvs_pkg::REQ_WRITE);
      wx = {req_world_x[15], req_world_x};
      wy = {req_world_y[15], req_world_y};
      wz = {req_world_z[15], req_world_z};
      if (is_write) begin
         case (req_place_face)
            cvs_pkg::FACE_XN: wx = wx - CB'(1);
            cvs_pkg::FACE_XP: wx = wx + CB'(1);
            cvs_pkg::FACE_YN: wy = wy - CB'(1);
            cvs_pkg::FACE_YP: wy = wy + CB'(1);
            cvs_pkg::FACE_ZN: wz = wz - CB'(1);
            cvs_pkg::FACE_ZP: wz = wz + CB'(1);
            default: ;
         endcase
      end

      cx = wx[SL+WL-1:SL];
      cz = wz[SL+WL-1:SL];
      lx = wx[SL-1:0];
      lz = wz[SL-1:0];
      ly = wy[TL-1:0];

      in_world = (wx[CB-1:SL+WL] == '0) && (wz[CB-1:SL+WL] == '0) && (wy[CB-1:TL] == '0);
      addr     = {cx, cz, lx, ly, lz};

      mask = '0;
      mask[cvs_pkg::MASK_OWN] = 1'b1;
      if (lx == cvs_pkg::LOCAL_LAST) begin
         mask[cvs_pkg::MASK_POS_X] = (cx != cvs_pkg::CHUNK_LAST);
      end else if (lx == cvs_pkg::LOCAL_FIRST) begin
         mask[cvs_pkg::MASK_NEG_X] = (cx != cvs_pkg::CHUNK_FIRST);
      end
      if (lz == cvs_pkg::LOCAL_LAST) begin
         mask[cvs_pkg::MASK_POS_Z] = (cz != cvs_pkg::CHUNK_LAST);
      end else if (lz == cvs_pkg::LOCAL_FIRST) begin
         mask[cvs_pkg::MASK_NEG_Z] = (cz != cvs_pkg::CHUNK_FIRST);
      end
   end

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_move);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AB'(1);
         if (clr_addr_ff == AB'(cvs_pkg::STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      ram_wr_en   = clr_busy_ff || (req_fire && is_write && in_world);
      ram_wr_addr = clr_busy_ff ? clr_addr_ff : addr;
      ram_wr_data = clr_busy_ff ? '0 : req_new_block_id[IB-1:0];

      s1_valid_in = req_fire || (s1_valid_ff && !s1_move);
      s1_in = s1_ff;
      if (req_fire) begin
         s1_in.in_world = in_world;
         s1_in.is_read  = !is_write;
         s1_in.mask     = (is_write && in_world) ? mask : '0;
      end

      rsp_valid_in       = s1_move || (rsp_valid_ff && !rsp_ready);
      rsp_in_world_in    = rsp_in_world_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_remesh_mask_in = rsp_remesh_mask_ff;
      if (s1_move) begin
         rsp_in_world_in    = s1_ff.in_world;
         rsp_read_value_in  = (s1_ff.in_world && s1_ff.is_read) ? 8'(ram_rd_data) : '0;
         rsp_remesh_mask_in = s1_ff.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff              <= s1_in;
      rsp_in_world_ff    <= rsp_in_world_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_remesh_mask_ff <= rsp_remesh_mask_in;
   end

   cvs_ram #(
      .WIDTH (IB),
      .DEPTH (cvs_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_world    = rsp_in_world_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_remesh_mask = rsp_remesh_mask_ff;

endmodule

// ===== hw/rtl/cvs_ram.sv =====
`timescale 1ns / 1ps

module cvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/voxel_store_checker.sv =====
`timescale 1ns / 1ps

module voxel_store_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic signed [15:0] req_world_x,
   input  logic signed [15:0] req_world_y,
   input  logic signed [15:0] req_world_z,
   input  logic [7:0]         req_new_block_id,
   input  logic [2:0]         req_place_face,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_in_world,
   input  logic [7:0]         rsp_read_value,
   input  logic [4:0]         rsp_remesh_mask,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int SIDE  = 1 << cvs_pkg::CHUNK_SIDE_LOG;
   localparam int TALL  = 1 << cvs_pkg::CHUNK_TALL_LOG;
   localparam int WORLD = 1 << cvs_pkg::WORLD_CHUNKS_LOG;
   localparam int AB    = cvs_pkg::ADDR_BITS;

   typedef struct packed {
      logic       in_world;
      logic [7:0] read_value;
      logic [4:0] remesh_mask;
   } voxel_rsp_type;

   logic [cvs_pkg::ID_BITS-1:0] voxel_ids [cvs_pkg::STORE_DEPTH];
   voxel_rsp_type               awaited_rsp_q [$];
   int                          err_count = 0;
   int                          pending = 0;
   int                          rsp_count = 0;

   assign mismatches  = err_count;
   assign outstanding = pending;

   initial begin
      foreach (voxel_ids[i]) voxel_ids[i] = '0;
   end

   task automatic note_mismatch(input string msg);
      $display("mismatch at response %0d: %s", rsp_count, msg);
      err_count++;
   endtask

   // floor split by shift/and on signed ints; store is updated in beat order
   function automatic voxel_rsp_type resolve_voxel(input logic op,
                                                   input logic signed [15:0] x,
                                                   input logic signed [15:0] y,
                                                   input logic signed [15:0] z,
                                                   input logic [7:0] id,
                                                   input logic [2:0] face);
      int            wx, wy, wz;
      int            cx, cy, cz, lx, ly, lz;
      logic [AB-1:0] addr;
      voxel_rsp_type r;
      wx = int'(x);
      wy = int'(y);
      wz = int'(z);
      r  = '0;
      if (op == cvs_pkg::REQ_WRITE) begin
         case (face)
            cvs_pkg::FACE_XN: wx = wx - 1;
            cvs_pkg::FACE_XP: wx = wx + 1;
            cvs_pkg::FACE_YN: wy = wy - 1;
            cvs_pkg::FACE_YP: wy = wy + 1;
            cvs_pkg::FACE_ZN: wz = wz - 1;
            cvs_pkg::FACE_ZP: wz = wz + 1;
            default: ;
         endcase
      end
      cx = wx >>> cvs_pkg::CHUNK_SIDE_LOG;
      cy = wy >>> cvs_pkg::CHUNK_TALL_LOG;
      cz = wz >>> cvs_pkg::CHUNK_SIDE_LOG;
      lx = wx & (SIDE - 1);
      ly = wy & (TALL - 1);
      lz = wz & (SIDE - 1);
      r.in_world = (cy == 0) && (cx >= 0) && (cx < WORLD) && (cz >= 0) && (cz < WORLD);
      if (r.in_world) begin
         addr = AB'((((cx * WORLD + cz) * SIDE + lx) * TALL + ly) * SIDE + lz);
         if (op == cvs_pkg::REQ_WRITE) begin
            voxel_ids[addr] = id[cvs_pkg::ID_BITS-1:0];
            r.remesh_mask[cvs_pkg::MASK_OWN] = 1'b1;
            if (lx == SIDE - 1) begin
               if (cx + 1 < WORLD) r.remesh_mask[cvs_pkg::MASK_POS_X] = 1'b1;
            end else if (lx == 0) begin
               if (cx > 0) r.remesh_mask[cvs_pkg::MASK_NEG_X] = 1'b1;
            end
            if (lz == SIDE - 1) begin
               if (cz + 1 < WORLD) r.remesh_mask[cvs_pkg::MASK_POS_Z] = 1'b1;
            end else if (lz == 0) begin
               if (cz > 0) r.remesh_mask[cvs_pkg::MASK_NEG_Z] = 1'b1;
            end
         end else begin
            r.read_value = 8'(voxel_ids[addr]);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      voxel_rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (awaited_rsp_q.size() == 0) begin
               note_mismatch("response beat with nothing expected");
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_in_world !== want.in_world)
                  note_mismatch($sformatf("in_world got %b want %b",
                                          rsp_in_world, want.in_world));
               if (rsp_read_value !== want.read_value)
                  note_mismatch($sformatf("read_value got %h want %h",
                                          rsp_read_value, want.read_value));
               if (rsp_remesh_mask !== want.remesh_mask)
                  note_mismatch($sformatf("remesh_mask got %b want %b",
                                          rsp_remesh_mask, want.remesh_mask));
            end
            rsp_count++;
         end
         if (req_valid && req_ready === 1'b1)
            awaited_rsp_q.push_back(resolve_voxel(req_type, req_world_x, req_world_y,
                                                  req_world_z, req_new_block_id,
                                                  req_place_face));
         pending = awaited_rsp_q.size();
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 900000;
   localparam int HISTORY_MAX  = 64;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } coord_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_type;
   logic signed [15:0] req_world_x;
   logic signed [15:0] req_world_y;
   logic signed [15:0] req_world_z;
   logic [7:0]         req_new_block_id;
   logic [2:0]         req_place_face;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_in_world;
   logic [7:0]         rsp_read_value;
   logic [4:0]         rsp_remesh_mask;
   int                 mismatches;
   int                 outstanding;

   int                 cycle_count = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 mode_left = 0;
   coord_type          written_q [$];

   chunked_voxel_store_core uut (.*);

   voxel_store_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: modes of free flow, light and heavy random stall, blocked stretches
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(64, 256);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= mode_left[3];
      endcase
   end

   task automatic send_beat(input logic op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z,
                            input logic [7:0] id, input logic [2:0] face);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_type         <= op;
      req_world_x      <= x;
      req_world_y      <= y;
      req_world_z      <= z;
      req_new_block_id <= id;
      req_place_face   <= face;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   initial begin
      int                 pick;
      logic               op;
      logic signed [15:0] x, y, z;
      logic signed [15:0] tx, ty, tz;
      logic [7:0]         id;
      logic [2:0]         face;
      coord_type          spot;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= cvs_pkg::REQ_READ;
      req_world_x      <= '0;
      req_world_y      <= '0;
      req_world_z      <= '0;
      req_new_block_id <= '0;
      req_place_face   <= cvs_pkg::FACE_NONE;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: corners, chunk edges, every face, out-of-world and overflow steps
      send_beat(cvs_pkg::REQ_READ,  0, 0, 0, 8'h00, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_WRITE, 0, 0, 0, 8'hFF, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_READ,  0, 0, 0, 8'h00, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_WRITE, 63, 31, 63, 8'h01, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_WRITE, 15, 5, 16, 8'h5A, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_WRITE, 32, 5, 47, 8'hA5, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h11, cvs_pkg::FACE_XN);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h22, cvs_pkg::FACE_XP);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h33, cvs_pkg::FACE_YN);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h44, cvs_pkg::FACE_YP);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h55, cvs_pkg::FACE_ZN);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h66, cvs_pkg::FACE_ZP);
      send_beat(cvs_pkg::REQ_WRITE, 20, 10, 20, 8'h77, cvs_pkg::FACE_SPARE);
      send_beat(cvs_pkg::REQ_WRITE, 5, 31, 5, 8'h88, cvs_pkg::FACE_YP);
      send_beat(cvs_pkg::REQ_WRITE, 0, 0, 0, 8'h99, cvs_pkg::FACE_XN);
      send_beat(cvs_pkg::REQ_WRITE, 16'sh7FFF, 3, 3, 8'hC3, cvs_pkg::FACE_XP);
      send_beat(cvs_pkg::REQ_WRITE, 16'sh8000, 3, 3, 8'h3C, cvs_pkg::FACE_XN);
      send_beat(cvs_pkg::REQ_WRITE, 3, 16'sh8000, 3, 8'hF0, cvs_pkg::FACE_YN);
      send_beat(cvs_pkg::REQ_WRITE, 3, 3, 16'sh7FFF, 8'h0F, cvs_pkg::FACE_ZP);
      send_beat(cvs_pkg::REQ_READ,  -16'sd1, 0, 0, 8'hFF, cvs_pkg::FACE_XP);
      send_beat(cvs_pkg::REQ_READ,  64, 3, 3, 8'h00, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_READ,  3, -16'sd1, 3, 8'h00, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_READ,  63, 31, 63, 8'hAA, cvs_pkg::FACE_XN);
      send_beat(cvs_pkg::REQ_READ,  19, 10, 20, 8'h00, cvs_pkg::FACE_NONE);
      send_beat(cvs_pkg::REQ_READ,  20, 10, 20, 8'h00, cvs_pkg::FACE_NONE);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         id   = 8'($urandom);
         face = 3'($urandom_range(0, 7));
         op   = cvs_pkg::REQ_READ;
         x    = 16'($urandom_range(0, 63));
         y    = 16'($urandom_range(0, 31));
         z    = 16'($urandom_range(0, 63));
         if (pick < 45) begin
            op = cvs_pkg::REQ_WRITE;
            if (pick >= 35) begin
               x = 16'(($urandom_range(0, 3) << 4) | ($urandom_range(0, 1) ? 15 : 0));
               z = 16'(($urandom_range(0, 3) << 4) | ($urandom_range(0, 1) ? 15 : 0));
            end
            tx = x;
            ty = y;
            tz = z;
            case (face)
               cvs_pkg::FACE_XN: tx = x - 16'sd1;
               cvs_pkg::FACE_XP: tx = x + 16'sd1;
               cvs_pkg::FACE_YN: ty = y - 16'sd1;
               cvs_pkg::FACE_YP: ty = y + 16'sd1;
               cvs_pkg::FACE_ZN: tz = z - 16'sd1;
               cvs_pkg::FACE_ZP: tz = z + 16'sd1;
               default: ;
            endcase
            written_q.push_back('{x: tx, y: ty, z: tz});
            if (written_q.size() > HISTORY_MAX) void'(written_q.pop_front());
         end else if (pick < 75) begin
            if (written_q.size() != 0) begin
               spot = written_q[$urandom_range(0, written_q.size() - 1)];
               x = spot.x;
               y = spot.y;
               z = spot.z;
            end
         end else if (pick >= 85) begin
            op = 1'($urandom);
            x  = 16'($urandom);
            y  = 16'($urandom);
            z  = 16'($urandom);
         end
         send_beat(op, x, y, z, id, face);
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
